// ===== rtl/bgu_pkg.sv =====
// Shared types and constants for the bilinear grid upscaler.
// Used by every module under rtl/; depends on nothing else.
package bgu_pkg;

    // Field widths
    localparam int H_W         = 24;  // source height sample
    localparam int OUT_W       = 28;  // interpolated height, 4 extra fraction bits
    localparam int COORD_W     = 12;  // render row / column
    localparam int SHIFT_W     = 2;   // scale_shift register
    localparam int CFG_DATA_W  = 11;  // widest configuration register
    localparam int CFG_IDX_W   = 1;
    localparam int PROD_W      = 30;  // 6-bit signed weight times a sample
    localparam int MAX_SIDE_DEF = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIDE = 1'b1;

    // Largest supported scale shift (4x)
    localparam logic [SHIFT_W-1:0] MAX_SHIFT = 2'd2;

    // One render point handed from the sequencer to the interpolator
    typedef struct packed {
        logic [1:0]         ay;     // rows up from the current sample
        logic [1:0]         ax;     // columns left of the current sample
        logic [SHIFT_W-1:0] shift;  // effective log2 of the factor
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
        logic               done;
    } step_t;

endpackage

// ===== rtl/bgu_line_store.sv =====
// Line store: one source row of height samples, one write and one read port.
// Read data is registered. Uses bgu_pkg for the sample width.
module bgu_line_store #(
    parameter int DEPTH = bgu_pkg::MAX_SIDE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic signed [bgu_pkg::H_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic signed [bgu_pkg::H_W-1:0] rdata
);

    logic signed [bgu_pkg::H_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; output holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bgu_interp.sv =====
// Interpolation datapath: four weight products, then sum and scale into the
// output register. Stall-all pipeline of two stages. Uses bgu_pkg types.
module bgu_interp (
    input  logic                               clk,
    input  logic                               rst_n,
    // render point from the sequencer
    input  logic                               step_valid,
    input  bgu_pkg::step_t                     step,
    output logic                               step_ready,
    input  logic signed [bgu_pkg::H_W-1:0]     cur_h,
    input  logic signed [bgu_pkg::H_W-1:0]     left_h,
    input  logic signed [bgu_pkg::H_W-1:0]     up_h,
    input  logic signed [bgu_pkg::H_W-1:0]     upleft_h,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [bgu_pkg::OUT_W-1:0]   out_height,
    output logic [bgu_pkg::COORD_W-1:0]        out_row,
    output logic [bgu_pkg::COORD_W-1:0]        out_col,
    output logic                               out_last,
    output logic                               grid_done
);

    localparam int PROD_W = bgu_pkg::PROD_W;

    logic                                 adv;
    logic [2:0]                           f_val;
    logic [2:0]                           wy0;
    logic [2:0]                           wy1;
    logic [2:0]                           wx0;
    logic [2:0]                           wx1;
    logic [4:0]                           w_cur;
    logic [4:0]                           w_left;
    logic [4:0]                           w_up;
    logic [4:0]                           w_ul;
    logic                                 a_valid_reg;
    bgu_pkg::step_t                       a_tag_reg;
    logic signed [bgu_pkg::PROD_W-1:0]    p_cur_reg;
    logic signed [bgu_pkg::PROD_W-1:0]    p_left_reg;
    logic signed [bgu_pkg::PROD_W-1:0]    p_up_reg;
    logic signed [bgu_pkg::PROD_W-1:0]    p_ul_reg;
    logic signed [bgu_pkg::PROD_W-1:0]    sum;
    logic signed [bgu_pkg::PROD_W-1:0]    scaled;
    logic [2:0]                           scale_amt;
    logic                                 out_valid_reg;
    logic signed [bgu_pkg::OUT_W-1:0]     height_reg;
    logic [bgu_pkg::COORD_W-1:0]          row_reg;
    logic [bgu_pkg::COORD_W-1:0]          col_reg;
    logic                                 last_reg;
    logic                                 done_reg;

    // Whole pipeline moves when the output register is free or being taken
    assign adv        = !out_valid_reg || !out_stall;
    assign step_ready = adv;

    // Corner weights; they sum to F*F
    always_comb
    begin
        f_val  = 3'(3'd1 << step.shift);
        wy1    = {1'b0, step.ay};
        wx1    = {1'b0, step.ax};
        wy0    = f_val - wy1;
        wx0    = f_val - wx1;
        w_cur  = 5'({2'b0, wy0} * {2'b0, wx0});
        w_left = 5'({2'b0, wy0} * {2'b0, wx1});
        w_up   = 5'({2'b0, wy1} * {2'b0, wx0});
        w_ul   = 5'({2'b0, wy1} * {2'b0, wx1});
    end

    // Stage A: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= step_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && step_valid)
        begin
            a_tag_reg  <= step;
            p_cur_reg  <= PROD_W'($signed({1'b0, w_cur})  * cur_h);
            p_left_reg <= PROD_W'($signed({1'b0, w_left}) * left_h);
            p_up_reg   <= PROD_W'($signed({1'b0, w_up})   * up_h);
            p_ul_reg   <= PROD_W'($signed({1'b0, w_ul})   * upleft_h);
        end
    end

    // Stage B: sum, then times 16/(F*F) as a left shift by 4 - 2*shift
    always_comb
    begin
        sum       = p_cur_reg + p_left_reg + p_up_reg + p_ul_reg;
        scale_amt = 3'd4 - {a_tag_reg.shift, 1'b0};
        scaled    = sum <<< scale_amt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && a_valid_reg)
        begin
            height_reg <= scaled[bgu_pkg::OUT_W-1:0];
            row_reg    <= a_tag_reg.row;
            col_reg    <= a_tag_reg.col;
            last_reg   <= a_tag_reg.last;
            done_reg   <= a_tag_reg.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_height = height_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign out_last   = last_reg;
    assign grid_done  = done_reg;

endmodule

// ===== rtl/bilinear_grid_upscaler.sv =====
// Top level of the bilinear grid upscaler: config registers, position counters,
// point sequencer and neighbor registers. Uses bgu_pkg, bgu_line_store, bgu_interp.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  input     | in_valid / in_stall | height_sample
//  result    | out_valid/out_stall | out_height, out_row, out_col, out_last,
//            |                     | grid_done
//  config    | cfg_we              | cfg_index, cfg_data
//
// Each input transaction is accepted, then its N render points are issued, N = 1,
// F or F*F (up to 16 at 4x), one point a cycle into the interpolator unless an
// output stall holds it; the next input is taken after the last point. Results
// pass the product and output registers; an output stall freezes the whole
// interpolator and the sequencer. The line store needs no clearing pass: row 0
// never uses the upper neighbors. Reset clears the counters and neighbor registers.
module bilinear_grid_upscaler #(
    parameter int MAX_SIDE = bgu_pkg::MAX_SIDE_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [bgu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bgu_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [bgu_pkg::H_W-1:0]        height_sample,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [bgu_pkg::OUT_W-1:0]      out_height,
    output logic [bgu_pkg::COORD_W-1:0]           out_row,
    output logic [bgu_pkg::COORD_W-1:0]           out_col,
    output logic                                  out_last,
    output logic                                  grid_done
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = ($clog2(MAX_SIDE + 1) > bgu_pkg::CFG_DATA_W) ?
                        $clog2(MAX_SIDE + 1) : bgu_pkg::CFG_DATA_W;

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t                                state_reg;
    logic [bgu_pkg::SHIFT_W-1:0]           scale_shift_reg;
    logic [bgu_pkg::CFG_DATA_W-1:0]        source_side_reg;
    logic [CW-1:0]                         row_count_reg;
    logic [CW-1:0]                         col_count_reg;
    logic signed [bgu_pkg::H_W-1:0]        h_reg;
    logic signed [bgu_pkg::H_W-1:0]        left_reg;
    logic signed [bgu_pkg::H_W-1:0]        upleft_reg;
    logic [1:0]                            ay_reg;
    logic [1:0]                            ax_reg;

    logic [bgu_pkg::SHIFT_W-1:0]           eff_shift;
    logic [1:0]                            f_m1;
    logic [SW-1:0]                         side_ext;
    logic [SW-1:0]                         side_eff;
    logic [SW-1:0]                         side_m1;
    logic                                  row_last;
    logic                                  col_last;
    logic                                  in_fire;
    logic                                  step_ready;
    logic                                  step_valid;
    logic                                  step_fire;
    logic                                  final_step;
    bgu_pkg::step_t                        step;
    logic signed [bgu_pkg::H_W-1:0]        mem_rdata;
    logic signed [bgu_pkg::H_W-1:0]        up_h;
    logic [bgu_pkg::COORD_W-1:0]           row_base;
    logic [bgu_pkg::COORD_W-1:0]           col_base;

    // Effective configuration
    always_comb
    begin
        eff_shift = (scale_shift_reg > bgu_pkg::MAX_SHIFT) ? bgu_pkg::MAX_SHIFT
                                                          : scale_shift_reg;
        f_m1      = 2'((3'd1 << eff_shift) - 3'd1);
        side_ext  = SW'(source_side_reg);
        if (side_ext == '0)
        begin
            side_eff = SW'(1);
        end
        else if (side_ext > SW'(MAX_SIDE))
        begin
            side_eff = SW'(MAX_SIDE);
        end
        else
        begin
            side_eff = side_ext;
        end
        side_m1  = side_eff - SW'(1);
        row_last = (SW'(row_count_reg) == side_m1);
        col_last = (SW'(col_count_reg) == side_m1);
    end

    // Handshakes
    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign step_valid = (state_reg == S_RUN);
    assign step_fire  = step_valid && step_ready;
    assign final_step = (ay_reg == 2'd0) && (ax_reg == 2'd0);

    // Upper neighbor is only meaningful below row 0
    assign up_h = (row_count_reg == '0) ? '0 : mem_rdata;

    // Render point descriptor
    always_comb
    begin
        row_base   = bgu_pkg::COORD_W'(row_count_reg) << eff_shift;
        col_base   = bgu_pkg::COORD_W'(col_count_reg) << eff_shift;
        step.ay    = ay_reg;
        step.ax    = ax_reg;
        step.shift = eff_shift;
        step.row   = row_base - bgu_pkg::COORD_W'(ay_reg);
        step.col   = col_base - bgu_pkg::COORD_W'(ax_reg);
        step.last  = final_step;
        step.done  = final_step && row_last && col_last;
    end

    // Sequencer, counters, neighbors and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scale_shift_reg <= '0;
            source_side_reg <= bgu_pkg::CFG_DATA_W'(1);
            row_count_reg   <= '0;
            col_count_reg   <= '0;
            left_reg        <= '0;
            upleft_reg      <= '0;
            ay_reg          <= '0;
            ax_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bgu_pkg::REG_SCALE_SHIFT: scale_shift_reg <= cfg_data[bgu_pkg::SHIFT_W-1:0];
                    bgu_pkg::REG_SOURCE_SIDE: source_side_reg <= cfg_data;
                    default: ;
                endcase
                row_count_reg <= '0;
                col_count_reg <= '0;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (in_fire)
                        begin
                            ay_reg    <= (row_count_reg == '0) ? 2'd0 : f_m1;
                            ax_reg    <= (col_count_reg == '0) ? 2'd0 : f_m1;
                            state_reg <= S_RUN;
                        end
                    end
                    S_RUN:
                    begin
                        if (step_fire)
                        begin
                            if (final_step)
                            begin
                                left_reg   <= h_reg;
                                upleft_reg <= up_h;
                                state_reg  <= S_IDLE;
                                if (col_last)
                                begin
                                    col_count_reg <= '0;
                                    row_count_reg <= row_last ? '0 : row_count_reg + CW'(1);
                                end
                                else
                                begin
                                    col_count_reg <= col_count_reg + CW'(1);
                                end
                            end
                            else if (ax_reg == 2'd0)
                            begin
                                ax_reg <= (col_count_reg == '0) ? 2'd0 : f_m1;
                                ay_reg <= ay_reg - 2'd1;
                            end
                            else
                            begin
                                ax_reg <= ax_reg - 2'd1;
                            end
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    // Current sample capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            h_reg <= height_sample;
        end
    end

    // Previous source row
    bgu_line_store #(
        .DEPTH (MAX_SIDE),
        .AW    (CW)
    ) u_line_store (
        .clk   (clk),
        .we    (step_fire && final_step),
        .waddr (col_count_reg),
        .wdata (h_reg),
        .re    (in_fire),
        .raddr (col_count_reg),
        .rdata (mem_rdata)
    );

    // Interpolation datapath and result register
    bgu_interp u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step       (step),
        .step_ready (step_ready),
        .cur_h      (h_reg),
        .left_h     (left_reg),
        .up_h       (up_h),
        .upleft_h   (upleft_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_height (out_height),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_last   (out_last),
        .grid_done  (grid_done)
    );

    // Checks
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grid_done |-> out_last)
        else $error("grid_done without out_last");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !cfg_we |=> state_reg == S_RUN)
        else $error("accepted transaction did not start the sequencer");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(col_count_reg) < side_eff && SW'(row_count_reg) < side_eff)
        else $error("position counter outside the grid");

    a_store_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && final_step |=> state_reg == S_IDLE && !step_valid)
        else $error("sequencer kept running after its final point");

endmodule

// ===== verif/tb_bilinear_grid_upscaler.sv =====
// Self-checking testbench for bilinear_grid_upscaler: an in-bench predictor of the
// upsampled render points, a queue-fed source driver, a stalling result monitor.
// Depends on rtl/bgu_pkg.sv and the RTL of bilinear_grid_upscaler.
module tb_bilinear_grid_upscaler;

    localparam int GRID_MAX     = bgu_pkg::MAX_SIDE_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 250;
    localparam int PRINT_CAP    = 40;

    // One expected render point
    typedef struct packed {
        logic [bgu_pkg::OUT_W-1:0]   height;
        logic [bgu_pkg::COORD_W-1:0] row;
        logic [bgu_pkg::COORD_W-1:0] col;
        logic                        last;
        logic                        done;
    } render_point_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [bgu_pkg::CFG_IDX_W-1:0]     cfg_index = bgu_pkg::REG_SCALE_SHIFT;
    logic [bgu_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic signed [bgu_pkg::H_W-1:0]    height_sample = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [bgu_pkg::OUT_W-1:0]  out_height;
    logic [bgu_pkg::COORD_W-1:0]       out_row;
    logic [bgu_pkg::COORD_W-1:0]       out_col;
    logic                              out_last;
    logic                              grid_done;

    bilinear_grid_upscaler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .height_sample (height_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_height    (out_height),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_last      (out_last),
        .grid_done     (grid_done)
    );

    // Clock: period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stimulus and expectation stores
    logic signed [bgu_pkg::H_W-1:0] pending_heights [$];
    render_point_t                  expected_points [$];
    int                             mismatch_count = 0;
    bit                             no_idle = 1'b0;
    int                             hold_ticket = 0;
    logic                           took_height = 1'b0;
    logic                           took_result = 1'b0;

    // Predictor state: registers, line store, neighbors, source position
    logic [bgu_pkg::SHIFT_W-1:0]    scale_reg = '0;
    logic [bgu_pkg::CFG_DATA_W-1:0] side_reg = 11'd1;
    logic signed [bgu_pkg::H_W-1:0] line_mem [0:GRID_MAX-1];
    logic signed [bgu_pkg::H_W-1:0] left_h = '0;
    logic signed [bgu_pkg::H_W-1:0] upper_left_h = '0;
    int unsigned                    src_row = 0;
    int unsigned                    src_col = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // Mostly random heights, with the field extremes mixed in
    function automatic logic signed [bgu_pkg::H_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(bgu_pkg::H_W-1){1'b0}}};
            1: return {1'b0, {(bgu_pkg::H_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return bgu_pkg::H_W'($urandom);
        endcase
    endfunction

    // Render points closed by one source sample, in render raster order
    task automatic predict_render_points(input logic signed [bgu_pkg::H_W-1:0] h);
        int unsigned   shift_eff, f, side_eff, r, c;
        int            n_r, n_c, n_pts, k;
        longint        hv, up_v, lf_v, ul_v, scl, acc, wy0, wy1, wx0, wx1;
        bit            final_cell;
        render_point_t pt;
        shift_eff = (scale_reg > bgu_pkg::MAX_SHIFT) ? bgu_pkg::MAX_SHIFT : scale_reg;
        f = 1 << shift_eff;
        side_eff = (side_reg == 0) ? 1 : (side_reg > GRID_MAX) ? GRID_MAX : side_reg;
        if (src_row >= side_eff)
            src_row = 0;
        if (src_col >= side_eff)
            src_col = 0;
        r = src_row;
        c = src_col;
        hv = h;
        up_v = line_mem[c];
        lf_v = left_h;
        ul_v = upper_left_h;
        scl = 16 >> (2 * shift_eff);
        n_r = (r == 0) ? 1 : f;
        n_c = (c == 0) ? 1 : f;
        n_pts = n_r * n_c;
        final_cell = (r == side_eff - 1) && (c == side_eff - 1);
        k = 0;
        for (int ay = n_r - 1; ay >= 0; ay--)
        begin
            for (int ax = n_c - 1; ax >= 0; ax--)
            begin
                wy0 = f - ay;
                wy1 = ay;
                wx0 = f - ax;
                wx1 = ax;
                acc = wy0 * wx0 * hv + wy0 * wx1 * lf_v
                    + wy1 * wx0 * up_v + wy1 * wx1 * ul_v;
                pt.height = bgu_pkg::OUT_W'(acc * scl);
                pt.row = bgu_pkg::COORD_W'(r * f - ay);
                pt.col = bgu_pkg::COORD_W'(c * f - ax);
                pt.last = (k == n_pts - 1);
                pt.done = pt.last && final_cell;
                expected_points.push_back(pt);
                k++;
            end
        end
        upper_left_h = up_v;
        line_mem[c] = h;
        left_h = h;
        if (c + 1 >= side_eff)
        begin
            src_col = 0;
            src_row = (r + 1 >= side_eff) ? 0 : r + 1;
        end
        else
            src_col = c + 1;
    endtask

    // Source driver: pops pending heights, random gap after each transaction
    always @(negedge clk)
    begin : source_driver
        int gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else if (!(in_valid && !took_height))
        begin
            if (took_height)
                gap_left = draw_wait();
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_heights.size() != 0)
            begin
                in_valid <= 1'b1;
                height_sample <= pending_heights.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random stall per transaction, plus long hold-offs on request
    always @(negedge clk)
    begin : result_receiver
        int stall_left;
        int hold_left;
        int hold_served;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_served = 0;
        end
        else
        begin
            if (hold_served != hold_ticket)
            begin
                hold_served = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (took_result)
                stall_left = draw_wait();
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: predict on accepted inputs, check accepted results
    always @(posedge clk)
    begin : txn_monitor
        render_point_t want;
        if (!rst_n)
        begin
            took_height <= 1'b0;
            took_result <= 1'b0;
        end
        else
        begin
            took_height <= in_valid && !in_stall;
            took_result <= out_valid && !out_stall;
            if (in_valid && !in_stall)
                predict_render_points(height_sample);
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                    report_mismatch($sformatf("unexpected result at render (%0d,%0d)",
                                              out_row, out_col));
                else
                begin
                    want = expected_points.pop_front();
                    if (out_height !== want.height)
                        report_mismatch($sformatf("out_height at (%0d,%0d): got %0h want %0h",
                                                  want.row, want.col, out_height, want.height));
                    if (out_row !== want.row)
                        report_mismatch($sformatf("out_row: got %0d want %0d",
                                                  out_row, want.row));
                    if (out_col !== want.col)
                        report_mismatch($sformatf("out_col: got %0d want %0d",
                                                  out_col, want.col));
                    if (out_last !== want.last)
                        report_mismatch($sformatf("out_last at (%0d,%0d): got %b want %b",
                                                  want.row, want.col, out_last, want.last));
                    if (grid_done !== want.done)
                        report_mismatch($sformatf("grid_done at (%0d,%0d): got %b want %b",
                                                  want.row, want.col, grid_done, want.done));
                end
            end
        end
    end

    // Block is idle once nothing is queued, offered or outstanding; checked at the
    // rising edge, where the driver's values have settled
    task automatic wait_for_idle();
        while (pending_heights.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Register write while idle; a write restarts the grid
    task automatic write_register(input logic [bgu_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bgu_pkg::CFG_DATA_W-1:0] value);
        wait_for_idle();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == bgu_pkg::REG_SCALE_SHIFT)
            scale_reg = value[bgu_pkg::SHIFT_W-1:0];
        else
            side_reg = value;
        src_row = 0;
        src_col = 0;
    endtask

    // Run limit
    initial
    begin
        #2000000;
        $display("bilinear_grid_upscaler regression: fail");
        $finish;
    end

    // Test sequence
    initial
    begin : sequence_main
        int                             sel;
        int                             side_val;
        int                             n_items;
        int                             random_items;
        logic [bgu_pkg::CFG_DATA_W-1:0] shift_word;
        for (int i = 0; i < GRID_MAX; i++)
            line_mem[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: 1x on a one-sample grid, every input closes the grid
        pending_heights.push_back({1'b0, {(bgu_pkg::H_W-1){1'b1}}});
        pending_heights.push_back({1'b1, {(bgu_pkg::H_W-1){1'b0}}});

        // 4x on a 3x3 grid with a long receiver hold-off, then wrap into a new grid
        write_register(bgu_pkg::REG_SCALE_SHIFT, 11'd2);
        write_register(bgu_pkg::REG_SOURCE_SIDE, 11'd3);
        hold_ticket++;
        pending_heights.push_back({1'b0, {(bgu_pkg::H_W-1){1'b1}}});
        pending_heights.push_back({1'b1, {(bgu_pkg::H_W-1){1'b0}}});
        pending_heights.push_back({1'b0, {(bgu_pkg::H_W-1){1'b1}}});
        pending_heights.push_back({1'b1, {(bgu_pkg::H_W-1){1'b0}}});
        pending_heights.push_back('0);
        pending_heights.push_back('1);
        pending_heights.push_back({1'b0, {(bgu_pkg::H_W-1){1'b1}}});
        pending_heights.push_back({1'b0, {(bgu_pkg::H_W-1){1'b1}}});
        pending_heights.push_back({1'b1, {(bgu_pkg::H_W-1){1'b0}}});
        repeat (3) pending_heights.push_back(pick_height());

        // Shift of three acts as 4x, side of zero acts as one
        write_register(bgu_pkg::REG_SCALE_SHIFT, 11'h7ff);
        write_register(bgu_pkg::REG_SOURCE_SIDE, 11'd0);
        repeat (2) pending_heights.push_back(pick_height());

        // 1x on a 3x3 grid, left part-way so the next write restarts it
        no_idle = 1'b1;
        write_register(bgu_pkg::REG_SCALE_SHIFT, 11'd0);
        write_register(bgu_pkg::REG_SOURCE_SIDE, 11'd3);
        repeat (4) pending_heights.push_back(pick_height());

        // Random phases: mostly whole small grids, some partial and oversized ones
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            case (sel)
                0:
                begin
                    side_val = 1;
                    n_items = $urandom_range(1, 4);
                end
                1:
                begin
                    side_val = 0;
                    n_items = $urandom_range(1, 3);
                end
                2:
                begin
                    side_val = GRID_MAX;
                    n_items = $urandom_range(3, 10);
                end
                3:
                begin
                    side_val = $urandom_range(GRID_MAX + 1, 2047);
                    n_items = $urandom_range(3, 10);
                end
                4, 5:
                begin
                    side_val = $urandom_range(7, 24);
                    n_items = 2 * side_val + $urandom_range(0, side_val - 1);
                end
                default:
                begin
                    side_val = $urandom_range(2, 6);
                    n_items = side_val * side_val * $urandom_range(1, 2);
                    if ($urandom_range(0, 2) == 0)
                        n_items += $urandom_range(1, side_val * side_val - 1);
                end
            endcase
            wait_for_idle();
            no_idle = ($urandom_range(0, 3) == 0);
            shift_word = bgu_pkg::CFG_DATA_W'($urandom);
            shift_word[bgu_pkg::SHIFT_W-1:0] = bgu_pkg::SHIFT_W'($urandom_range(0, 3));
            write_register(bgu_pkg::REG_SCALE_SHIFT, shift_word);
            write_register(bgu_pkg::REG_SOURCE_SIDE, bgu_pkg::CFG_DATA_W'(side_val));
            if ($urandom_range(0, 9) == 0)
                hold_ticket++;
            repeat (n_items) pending_heights.push_back(pick_height());
            random_items += n_items;
        end

        // Drain and let any stray result show up
        wait_for_idle();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("bilinear_grid_upscaler regression: pass");
        else
            $display("bilinear_grid_upscaler regression: fail");
        $finish;
    end

endmodule
